// ===== rtl/tsmh_pkg.sv =====
// ----------------------------------------------------------------------------
// tsmh_pkg
// Shared types and constants for the timestamp min-heap queue: request and
// response payloads, field widths and action codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsmh_pkg;

   // Fixed field widths of the request and response channels
   localparam int TS_BITS       = 64;
   localparam int PAY_PORT_BITS = 32;
   localparam int CNT_PORT_BITS = 7;

   // Action codes
   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_POP  = 1'b1;

   typedef struct packed {
      logic                     action;
      logic [TS_BITS-1:0]       new_timestamp;
      logic [PAY_PORT_BITS-1:0] new_payload;
   } req_type;

   typedef struct packed {
      logic                     ok;
      logic [TS_BITS-1:0]       popped_timestamp;
      logic [PAY_PORT_BITS-1:0] popped_payload;
      logic [CNT_PORT_BITS-1:0] count_after;
      logic                     head_valid;
      logic [TS_BITS-1:0]       head_timestamp;
      logic [PAY_PORT_BITS-1:0] head_payload;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/tsmh_mem.sv =====
// ----------------------------------------------------------------------------
// tsmh_mem
// Heap entry storage: one write port and two read ports with registered
// read data. Read data holds while its port is not enabled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsmh_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 96
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd0_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd0_addr,
   output logic      [WIDTH-1:0]         rd0_data,
   input  wire logic                     rd1_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd1_addr,
   output logic      [WIDTH-1:0]         rd1_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd0_data_ff;
   logic [WIDTH-1:0] rd1_data_ff;

   // Write entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read entries into the output registers
   always_ff @(posedge clock) begin
      if (rd0_en) begin
         rd0_data_ff <= mem_ff[rd0_addr];
      end
      if (rd1_en) begin
         rd1_data_ff <= mem_ff[rd1_addr];
      end
   end

   assign rd0_data = rd0_data_ff;
   assign rd1_data = rd1_data_ff;

endmodule

`default_nettype wire

// ===== rtl/tsmh_cmp.sv =====
// ----------------------------------------------------------------------------
// tsmh_cmp
// Shared timestamp comparator: flags a strictly earlier timestamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsmh_cmp
   import tsmh_pkg::*;
(
   input  wire logic [TS_BITS-1:0] ts_a,
   input  wire logic [TS_BITS-1:0] ts_b,
   output logic                    earlier
);

   // Flag a strictly before b; ties do not count
   assign earlier = (ts_a < ts_b);

endmodule

`default_nettype wire

// ===== rtl/timestamp_min_heap_queue.sv =====
// ----------------------------------------------------------------------------
// timestamp_min_heap_queue
// Event queue ordered by timestamp, kept as a binary min-heap in memory.
// Request channel (req_valid / req_stall / req_data): action push inserts
//   new_timestamp with new_payload; action pop removes the earliest event.
// Response channel (rsp_valid / rsp_stall / rsp_data): one response per
//   request with the ok flag, the popped event (zero unless a pop succeeded),
//   the fill count and the head of the queue after the request. A push to a
//   full queue or a pop from an empty queue returns ok = 0 and changes nothing.
// Sequencing: one request at a time, walked by a sequencer around one shared
//   timestamp comparator and a memory with registered reads. A push ends when
//   the event reaches the root or a compare stops it; a pop ends when the moved
//   entry reaches a leaf or a compare stops it; rejected requests and a pop of
//   the last event go straight to loading the response.
// Throughput: req_stall is high from acceptance until the response is
//   loaded, so a new request is taken while an earlier response still waits.
// Reset: the queue becomes empty at once; no clearing pass is needed.
// Stall: while rsp_stall holds the pending response, a finished request
//   waits before its response is loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module timestamp_min_heap_queue
   import tsmh_pkg::*;
#(
   parameter int DEPTH        = 64,
   parameter int PAYLOAD_BITS = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = AW + 2;
   localparam int EW = TS_BITS + PAYLOAD_BITS;

   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
   localparam logic [CW-1:0] CNT_ONE  = CW'(1);

   // Sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_UP_RD  = 3'd1;
   localparam logic [2:0] S_UP_CMP = 3'd2;
   localparam logic [2:0] S_POP_LD = 3'd3;
   localparam logic [2:0] S_DN_RD  = 3'd4;
   localparam logic [2:0] S_DN_L   = 3'd5;
   localparam logic [2:0] S_DN_R   = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0]               state_ff,     state_in;
   logic [CW-1:0]            count_ff,     count_in;
   logic [AW-1:0]            pos_ff,       pos_in;
   logic [EW-1:0]            cur_ff,       cur_in;
   logic [EW-1:0]            best_ff,      best_in;
   logic                     take_l_ff,    take_l_in;
   logic                     r_ok_ff,      r_ok_in;
   logic                     ok_ff,        ok_in;
   logic [TS_BITS-1:0]       popped_ts_ff, popped_ts_in;
   logic [PAY_PORT_BITS-1:0] popped_pay_ff, popped_pay_in;
   logic [EW-1:0]            head_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff,       rsp_in;

   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [EW-1:0]            wr_data;
   logic                     rd0_en;
   logic [AW-1:0]            rd0_addr;
   logic [EW-1:0]            rd0_data;
   logic                     rd1_en;
   logic [AW-1:0]            rd1_addr;
   logic [EW-1:0]            rd1_data;

   logic [TS_BITS-1:0]       cmp_a;
   logic [TS_BITS-1:0]       cmp_b;
   logic                     cmp_lt;
   logic                     rsp_load;

   logic [CW-1:0]            cnt_dec;
   logic [AW-1:0]            pos_dec;
   logic [AW-1:0]            parent;
   logic [LW-1:0]            l_idx;
   logic [LW-1:0]            r_idx;
   logic [LW-1:0]            n_ext;
   logic                     head_nz;

   // Index arithmetic around the current position
   assign cnt_dec = count_ff - CNT_ONE;
   assign pos_dec = pos_ff - AW'(1);
   assign parent  = pos_dec >> 1;
   assign l_idx   = {1'b0, pos_ff, 1'b1};
   assign r_idx   = {({1'b0, pos_ff} + (AW + 1)'(1)), 1'b0};
   assign n_ext   = LW'(count_ff);
   assign head_nz = (count_ff != '0);

   tsmh_mem #(
      .DEPTH (DEPTH),
      .WIDTH (EW)
   ) u_mem (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd0_en   (rd0_en),
      .rd0_addr (rd0_addr),
      .rd0_data (rd0_data),
      .rd1_en   (rd1_en),
      .rd1_addr (rd1_addr),
      .rd1_data (rd1_data)
   );

   tsmh_cmp u_cmp (
      .ts_a    (cmp_a),
      .ts_b    (cmp_b),
      .earlier (cmp_lt)
   );

   // Sequence one request through sift-up or sift-down
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      cur_in        = cur_ff;
      best_in       = best_ff;
      take_l_in     = take_l_ff;
      r_ok_in       = r_ok_ff;
      ok_in         = ok_ff;
      popped_ts_in  = popped_ts_ff;
      popped_pay_in = popped_pay_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = cur_ff;
      rd0_en        = 1'b0;
      rd0_addr      = pos_ff;
      rd1_en        = 1'b0;
      rd1_addr      = pos_ff;
      cmp_a         = cur_ff[EW-1:PAYLOAD_BITS];
      cmp_b         = rd0_data[EW-1:PAYLOAD_BITS];
      rsp_load      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               popped_ts_in  = '0;
               popped_pay_in = '0;
               if (req_data.action == ACT_PUSH) begin
                  if (count_ff == CNT_FULL) begin
                     ok_in    = 1'b0;
                     state_in = S_DONE;
                  end else begin
                     ok_in    = 1'b1;
                     cur_in   = {req_data.new_timestamp,
                                 PAYLOAD_BITS'(req_data.new_payload)};
                     pos_in   = count_ff[AW-1:0];
                     count_in = count_ff + CNT_ONE;
                     state_in = S_UP_RD;
                  end
               end else begin
                  if (!head_nz) begin
                     ok_in    = 1'b0;
                     state_in = S_DONE;
                  end else begin
                     // Take the root and fetch the last entry
                     ok_in         = 1'b1;
                     popped_ts_in  = head_ff[EW-1:PAYLOAD_BITS];
                     popped_pay_in = PAY_PORT_BITS'(head_ff[PAYLOAD_BITS-1:0]);
                     count_in      = cnt_dec;
                     rd0_en        = 1'b1;
                     rd0_addr      = cnt_dec[AW-1:0];
                     state_in      = (count_ff == CNT_ONE) ? S_DONE : S_POP_LD;
                  end
               end
            end
         end

         S_UP_RD: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               rd0_en   = 1'b1;
               rd0_addr = parent;
               state_in = S_UP_CMP;
            end
         end

         S_UP_CMP: begin
            // Move the parent down while the new event is strictly earlier
            cmp_a = cur_ff[EW-1:PAYLOAD_BITS];
            cmp_b = rd0_data[EW-1:PAYLOAD_BITS];
            wr_en = 1'b1;
            if (cmp_lt) begin
               wr_data  = rd0_data;
               pos_in   = parent;
               state_in = S_UP_RD;
            end else begin
               state_in = S_DONE;
            end
         end

         S_POP_LD: begin
            cur_in   = rd0_data;
            pos_in   = '0;
            state_in = S_DN_RD;
         end

         S_DN_RD: begin
            if (l_idx >= n_ext) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               rd0_en   = 1'b1;
               rd0_addr = l_idx[AW-1:0];
               rd1_en   = 1'b1;
               rd1_addr = r_idx[AW-1:0];
               r_ok_in  = (r_idx < n_ext);
               state_in = S_DN_L;
            end
         end

         S_DN_L: begin
            // Test the left child first
            cmp_a     = rd0_data[EW-1:PAYLOAD_BITS];
            cmp_b     = cur_ff[EW-1:PAYLOAD_BITS];
            take_l_in = cmp_lt;
            best_in   = cmp_lt ? rd0_data : cur_ff;
            state_in  = S_DN_R;
         end

         S_DN_R: begin
            // Then the right child against the smallest so far
            cmp_a = rd1_data[EW-1:PAYLOAD_BITS];
            cmp_b = best_ff[EW-1:PAYLOAD_BITS];
            wr_en = 1'b1;
            priority if (r_ok_ff && cmp_lt) begin
               wr_data  = rd1_data;
               pos_in   = r_idx[AW-1:0];
               state_in = S_DN_RD;
            end else if (take_l_ff) begin
               wr_data  = best_ff;
               pos_in   = l_idx[AW-1:0];
               state_in = S_DN_RD;
            end else begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // Build the response and hold it while stalled
   always_comb begin
      rsp_in                  = rsp_ff;
      rsp_valid_in            = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in            = 1'b1;
         rsp_in.ok               = ok_ff;
         rsp_in.popped_timestamp = popped_ts_ff;
         rsp_in.popped_payload   = popped_pay_ff;
         rsp_in.count_after      = CNT_PORT_BITS'(count_ff);
         rsp_in.head_valid       = head_nz;
         rsp_in.head_timestamp   = head_nz ? head_ff[EW-1:PAYLOAD_BITS] : '0;
         rsp_in.head_payload     = head_nz ?
                                   PAY_PORT_BITS'(head_ff[PAYLOAD_BITS-1:0]) : '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers; keep a copy of the root beside the memory
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      cur_ff        <= cur_in;
      best_ff       <= best_in;
      take_l_ff     <= take_l_in;
      r_ok_ff       <= r_ok_in;
      ok_ff         <= ok_in;
      popped_ts_ff  <= popped_ts_in;
      popped_pay_ff <= popped_pay_in;
      rsp_ff        <= rsp_in;
      if (wr_en && (wr_addr == '0)) begin
         head_ff <= wr_data;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== tb/timestamp_min_heap_queue_tb.sv =====
// ----------------------------------------------------------------------------
// timestamp_min_heap_queue_tb
// Self-checking bench for the timestamp min-heap queue. A shadow heap predicts
// the response of every accepted request. The stimulus runs a short directed
// opening, then alternating fill, drain and mixed sequences that reach the
// full and empty limits. Both channels take random gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timestamp_min_heap_queue_tb;
   import tsmh_pkg::*;

   localparam int HEAP_DEPTH   = 64;
   localparam int RUN_ITEMS    = 500;
   localparam int MAX_WAIT     = 18;
   localparam int SETTLE_TICKS = 60;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_LIMIT = 10;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   timestamp_min_heap_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow heap and scoreboard
   logic [TS_BITS-1:0]       heap_stamp [HEAP_DEPTH];
   logic [PAY_PORT_BITS-1:0] heap_data  [HEAP_DEPTH];
   int                       heap_fill = 0;

   req_type req_backlog[$];
   rsp_type pending_replies[$];

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  issued         = 0;
   int  planned_fill   = 0;
   int  send_gap       = 0;
   int  hold_left      = 0;
   bit  send_calm      = 1'b0;
   bit  hold_calm      = 1'b0;
   bit  timed_out      = 1'b0;
   logic next_valid;

   function automatic void swap_slots(int a, int b);
      logic [TS_BITS-1:0]       t;
      logic [PAY_PORT_BITS-1:0] p;
      t = heap_stamp[a];
      p = heap_data[a];
      heap_stamp[a] = heap_stamp[b];
      heap_data[a]  = heap_data[b];
      heap_stamp[b] = t;
      heap_data[b]  = p;
   endfunction

   // Apply one request to the shadow heap and return the response it should get
   function automatic rsp_type apply_heap_op(req_type op);
      rsp_type r;
      int      slot;
      int      parent;
      int      left;
      int      right;
      int      least;
      r = '0;
      if (op.action == ACT_PUSH) begin
         if (heap_fill < HEAP_DEPTH) begin
            slot = heap_fill;
            heap_stamp[slot] = op.new_timestamp;
            heap_data[slot]  = op.new_payload;
            // sift up while strictly earlier than the parent
            while (slot > 0) begin
               parent = (slot - 1) / 2;
               if (heap_stamp[slot] >= heap_stamp[parent]) break;
               swap_slots(slot, parent);
               slot = parent;
            end
            heap_fill++;
            r.ok = 1'b1;
         end
      end else if (heap_fill > 0) begin
         r.ok               = 1'b1;
         r.popped_timestamp = heap_stamp[0];
         r.popped_payload   = heap_data[0];
         heap_fill--;
         if (heap_fill > 0) begin
            heap_stamp[0] = heap_stamp[heap_fill];
            heap_data[0]  = heap_data[heap_fill];
            // sift down, left child tested first, swap only when strictly earlier
            slot = 0;
            while (slot < heap_fill) begin
               left  = 2 * slot + 1;
               right = 2 * slot + 2;
               least = slot;
               if (left < heap_fill && heap_stamp[left] < heap_stamp[least]) least = left;
               if (right < heap_fill && heap_stamp[right] < heap_stamp[least]) least = right;
               if (least == slot) break;
               swap_slots(slot, least);
               slot = least;
            end
         end
      end
      r.count_after = heap_fill[CNT_PORT_BITS-1:0];
      if (heap_fill > 0) begin
         r.head_valid     = 1'b1;
         r.head_timestamp = heap_stamp[0];
         r.head_payload   = heap_data[0];
      end
      return r;
   endfunction

   function automatic int draw_wait(bit calm);
      return calm ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch %s: expected %h, got %h", name, want, got);
      end
   endtask

   task automatic check_reply(rsp_type got);
      rsp_type want;
      if (pending_replies.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected response %h", got);
      end else begin
         want = pending_replies.pop_front();
         compare_field("ok", want.ok, got.ok);
         compare_field("popped_timestamp", want.popped_timestamp, got.popped_timestamp);
         compare_field("popped_payload", want.popped_payload, got.popped_payload);
         compare_field("count_after", want.count_after, got.count_after);
         compare_field("head_valid", want.head_valid, got.head_valid);
         compare_field("head_timestamp", want.head_timestamp, got.head_timestamp);
         compare_field("head_payload", want.head_payload, got.head_payload);
      end
   endtask

   // Stimulus builders; planned_fill tracks the expected depth to steer sequences
   function automatic logic [TS_BITS-1:0] rand_stamp();
      case ($urandom_range(0, 5))
         0: return TS_BITS'($urandom_range(0, 7));
         1: return '0;
         2: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [PAY_PORT_BITS-1:0] rand_payload();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_push(logic [TS_BITS-1:0] stamp, logic [PAY_PORT_BITS-1:0] pay);
      req_type op;
      op.action        = ACT_PUSH;
      op.new_timestamp = stamp;
      op.new_payload   = pay;
      req_backlog.push_back(op);
      issued++;
      if (planned_fill < HEAP_DEPTH) planned_fill++;
   endtask

   task automatic queue_pop();
      req_type op;
      op.action        = ACT_POP;
      op.new_timestamp = {$urandom, $urandom};
      op.new_payload   = $urandom;
      req_backlog.push_back(op);
      issued++;
      if (planned_fill > 0) planned_fill--;
   endtask

   // Drive requests: hold the payload while stalled, then load the next after its gap
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            pending_replies.push_back(apply_heap_op(req_data));
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (req_backlog.size() > 0) begin
               req_data <= req_backlog.pop_front();
               next_valid = 1'b1;
               if ($urandom_range(0, 24) == 0) send_calm = !send_calm;
               send_gap = draw_wait(send_calm);
            end
         end
         req_valid <= next_valid;
      end
   end

   // Accept and check responses, then stall for a random hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_reply(rsp_data);
            if ($urandom_range(0, 24) == 0) hold_calm = !hold_calm;
            hold_left = draw_wait(hold_calm);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int mode;
      int extra;
      int span;

      // Directed opening: empty pop, extremes, ties, drain past empty
      queue_pop();
      queue_push(64'd5, 32'h1111_1111);
      queue_push(64'd5, 32'h2222_2222);
      queue_push('0, '0);
      queue_push('1, '1);
      queue_push(64'd3, 32'h3333_3333);
      queue_push(64'd5, 32'h4444_4444);
      queue_push(64'd1, 32'h5555_5555);
      queue_push(64'h8000_0000_0000_0000, 32'h8000_0000);
      repeat (10) queue_pop();

      // Random sequences: fill to full and beyond, drain to empty and beyond, mix
      mode = 0;
      while (issued < RUN_ITEMS) begin
         case (mode % 3)
            0: begin
               while (planned_fill < HEAP_DEPTH) begin
                  if ($urandom_range(0, 99) < 15) queue_pop();
                  else queue_push(rand_stamp(), rand_payload());
               end
               extra = $urandom_range(1, 4);
               repeat (extra) queue_push(rand_stamp(), rand_payload());
            end
            1: begin
               while (planned_fill > 0) begin
                  if ($urandom_range(0, 99) < 15) queue_push(rand_stamp(), rand_payload());
                  else queue_pop();
               end
               extra = $urandom_range(1, 3);
               repeat (extra) queue_pop();
            end
            default: begin
               span = $urandom_range(20, 60);
               repeat (span) begin
                  if ($urandom_range(0, 1) == 0) queue_push(rand_stamp(), rand_payload());
                  else queue_pop();
               end
            end
         endcase
         mode++;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Wait for all requests to drain and every response to arrive
      while ((req_backlog.size() != 0 || req_valid || pending_replies.size() != 0)
             && cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      if (cycle_count >= CYCLE_LIMIT)
         timed_out = 1'b1;
      else
         repeat (SETTLE_TICKS) @(posedge clock);

      // Every request must have been sent and answered
      if (mismatch_count == 0 && !timed_out && req_backlog.size() == 0 && !req_valid
          && pending_replies.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
